// ===== rtl/scgc_pkg.sv =====
// Shared types and constants for the serial CRC generate/check block.
package scgc_pkg;

  localparam int unsigned DEGREE_W = 5;
  localparam int unsigned TAPS_W   = 16;
  localparam int unsigned APB_AW   = 4;
  localparam int unsigned APB_DW   = 32;

  localparam logic [1:0] REG_DEGREE = 2'd0;
  localparam logic [1:0] REG_TAPS   = 2'd1;
  localparam logic [1:0] REG_MODE   = 2'd2;

  localparam logic [DEGREE_W-1:0] DEGREE_RST = 5'd16;
  localparam logic [TAPS_W-1:0]   TAPS_RST   = 16'h1021;

  localparam int unsigned QUEUE_DEPTH = 4;

  typedef struct packed {
    logic data_bit;
    logic last_bit;
  } in_item_t;

  typedef struct packed {
    logic code_bit;
    logic is_crc_bit;
    logic frame_end;
    logic error_flag;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_ECHO,
    CMD_ECHO_CRC,
    CMD_CHECK
  } cmd_kind_e;

  // bit_val: echoed data bit, or the error flag for a check command
  typedef struct packed {
    cmd_kind_e kind;
    logic      bit_val;
  } cmd_t;

  localparam int unsigned CMD_W = $bits(cmd_t);

endpackage

// ===== rtl/serial_crc_generate_check.sv =====
// Serial CRC generator/checker with programmable generator polynomial.
// A result item passes through the command queue and the result register, and is held while the receiver does not pop.
// The front takes one input item per cycle while the queue is not full, and does one division step per accepted item.
// A last bit in generate mode yields 1 + degree result items, one per cycle from the back end while the receiver pops;
// the 4-entry command queue lets the front keep accepting during that burst.
// Reset: remainder zero, queue and result register empty, registers to 16 / 0x1021 / generate.
module serial_crc_generate_check #(
  parameter int unsigned MAX_DEGREE = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  scgc_pkg::in_item_t          data_i,
  output logic                        empty,
  input  logic                        pop,
  output scgc_pkg::out_item_t         result_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [scgc_pkg::APB_AW-1:0] paddr,
  input  logic [scgc_pkg::APB_DW-1:0] pwdata,
  output logic [scgc_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);

  localparam int unsigned DEG_W = $clog2(MAX_DEGREE + 1);
  localparam int unsigned QW    = scgc_pkg::CMD_W + MAX_DEGREE + DEG_W;

  logic [scgc_pkg::DEGREE_W-1:0] degree_q;
  logic [scgc_pkg::TAPS_W-1:0]   taps_q;
  logic                          check_q;
  logic                          cfg_wr;

  logic                  accept;
  logic                  cmd_valid;
  scgc_pkg::cmd_t        cmd_w, cmd_r;
  logic [MAX_DEGREE-1:0] crc_w, crc_r;
  logic [DEG_W-1:0]      deg_w, deg_r;
  logic                  q_full, q_empty, q_pop;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degree_q <= scgc_pkg::DEGREE_RST;
      taps_q   <= scgc_pkg::TAPS_RST;
      check_q  <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        scgc_pkg::REG_DEGREE: degree_q <= pwdata[scgc_pkg::DEGREE_W-1:0];
        scgc_pkg::REG_TAPS:   taps_q   <= pwdata[scgc_pkg::TAPS_W-1:0];
        scgc_pkg::REG_MODE:   check_q  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      scgc_pkg::REG_DEGREE: prdata = scgc_pkg::APB_DW'(degree_q);
      scgc_pkg::REG_TAPS:   prdata = scgc_pkg::APB_DW'(taps_q);
      scgc_pkg::REG_MODE:   prdata = scgc_pkg::APB_DW'(check_q);
      default:              prdata = '0;
    endcase
  end

  // data path
  assign full   = q_full;
  assign accept = push && !full;

  scgc_front #(
    .MAX_DEGREE(MAX_DEGREE),
    .DEG_W     (DEG_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_degree_i(degree_q),
    .cfg_taps_i  (taps_q),
    .cfg_check_i (check_q),
    .accept_i    (accept),
    .item_i      (data_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd_w),
    .crc_o       (crc_w),
    .deg_o       (deg_w)
  );

  scgc_queue #(
    .WIDTH(QW),
    .DEPTH(scgc_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_valid),
    .wdata_i({cmd_w, crc_w, deg_w}),
    .pop_i  (q_pop),
    .rdata_o({cmd_r, crc_r, deg_r}),
    .full_o (q_full),
    .empty_o(q_empty)
  );

  scgc_back #(
    .MAX_DEGREE(MAX_DEGREE),
    .DEG_W     (DEG_W)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_empty_i(q_empty),
    .cmd_i    (cmd_r),
    .crc_i    (crc_r),
    .deg_i    (deg_r),
    .q_pop_o  (q_pop),
    .pop_i    (pop),
    .empty_o  (empty),
    .result_o (result_o)
  );

  a_full_has_cmds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> !q_empty)
    else $error("queue full and empty at once");

  a_no_pop_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("command popped from empty queue");

  a_crc_not_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> !(result_o.is_crc_bit && result_o.error_flag))
    else $error("CRC bit item carries an error flag");

endmodule

// ===== rtl/scgc_front.sv =====
// Front end: remainder register, one division step per accepted item, command issue.
module scgc_front #(
  parameter int unsigned MAX_DEGREE = 16,
  parameter int unsigned DEG_W      = 5
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [scgc_pkg::DEGREE_W-1:0] cfg_degree_i,
  input  logic [scgc_pkg::TAPS_W-1:0]   cfg_taps_i,
  input  logic                          cfg_check_i,
  input  logic                          accept_i,
  input  scgc_pkg::in_item_t            item_i,
  output logic                          cmd_valid_o,
  output scgc_pkg::cmd_t                cmd_o,
  output logic [MAX_DEGREE-1:0]         crc_o,
  output logic [DEG_W-1:0]              deg_o
);

  localparam int unsigned CW = (DEG_W > scgc_pkg::DEGREE_W) ? DEG_W : scgc_pkg::DEGREE_W;

  logic [MAX_DEGREE-1:0]                 rem_q, rem_d;
  logic [CW-1:0]                         deg_ext;
  logic [DEG_W-1:0]                      deg;
  logic [MAX_DEGREE-1:0]                 mask, top_sel, taps, rem, nxt;
  logic [MAX_DEGREE+scgc_pkg::TAPS_W-1:0] taps_wide;
  logic                                  top;

  always_comb begin
    deg_ext = CW'(cfg_degree_i);
    if (deg_ext == '0) begin
      deg = DEG_W'(1);
    end else if (deg_ext > CW'(MAX_DEGREE)) begin
      deg = DEG_W'(MAX_DEGREE);
    end else begin
      deg = deg_ext[DEG_W-1:0];
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_DEGREE; i++) begin
      mask[i]    = DEG_W'(i) < deg;
      top_sel[i] = DEG_W'(i) == (deg - DEG_W'(1));
    end
  end

  assign taps_wide = {{MAX_DEGREE{1'b0}}, cfg_taps_i};
  assign taps      = taps_wide[MAX_DEGREE-1:0] & mask;
  assign rem       = rem_q & mask;
  assign top       = |(rem & top_sel);

  always_comb begin
    if (cfg_check_i) begin
      // codeword divided directly
      nxt = (((rem << 1) | MAX_DEGREE'(item_i.data_bit)) & mask) ^ (top ? taps : '0);
    end else begin
      // augmented division, message times x^D
      nxt = ((rem << 1) & mask) ^ ((top ^ item_i.data_bit) ? taps : '0);
    end
  end

  always_comb begin
    rem_d = rem_q;
    if (accept_i) begin
      rem_d = item_i.last_bit ? '0 : nxt;
    end
  end

  always_comb begin
    if (cfg_check_i) begin
      cmd_o.kind    = scgc_pkg::CMD_CHECK;
      cmd_o.bit_val = |nxt;
      cmd_valid_o   = accept_i && item_i.last_bit;
    end else begin
      cmd_o.kind    = item_i.last_bit ? scgc_pkg::CMD_ECHO_CRC : scgc_pkg::CMD_ECHO;
      cmd_o.bit_val = item_i.data_bit;
      cmd_valid_o   = accept_i;
    end
  end

  assign crc_o = nxt;
  assign deg_o = deg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else begin
      rem_q <= rem_d;
    end
  end

endmodule

// ===== rtl/scgc_queue.sv =====
// Short command queue between the front and back ends.
module scgc_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = cnt_q == CNT_W'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// ===== rtl/scgc_back.sv =====
// Back end: expands queued commands into result items, CRC bits MSB first.
module scgc_back #(
  parameter int unsigned MAX_DEGREE = 16,
  parameter int unsigned DEG_W      = 5
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_empty_i,
  input  scgc_pkg::cmd_t        cmd_i,
  input  logic [MAX_DEGREE-1:0] crc_i,
  input  logic [DEG_W-1:0]      deg_i,
  output logic                  q_pop_o,
  input  logic                  pop_i,
  output logic                  empty_o,
  output scgc_pkg::out_item_t   result_o
);

  logic [DEG_W-1:0]      cnt_q, cnt_d;
  logic                  out_valid_q, out_valid_d;
  scgc_pkg::out_item_t   result_q, res;
  logic                  done, load, crc_bit;
  logic [MAX_DEGREE-1:0] bit_sel;

  // cnt counts items sent for this command, echoed data bit included; bit deg-cnt goes out next
  always_comb begin
    for (int i = 0; i < MAX_DEGREE; i++) begin
      bit_sel[i] = DEG_W'(i) == (deg_i - cnt_q);
    end
  end
  assign crc_bit = |(crc_i & bit_sel);

  always_comb begin
    res  = '0;
    done = 1'b1;
    case (cmd_i.kind)
      scgc_pkg::CMD_CHECK: begin
        res.frame_end  = 1'b1;
        res.error_flag = cmd_i.bit_val;
      end
      scgc_pkg::CMD_ECHO: begin
        res.code_bit = cmd_i.bit_val;
      end
      scgc_pkg::CMD_ECHO_CRC: begin
        if (cnt_q == '0) begin
          res.code_bit = cmd_i.bit_val;
          done         = 1'b0;
        end else begin
          res.code_bit   = crc_bit;
          res.is_crc_bit = 1'b1;
          res.frame_end  = cnt_q == deg_i;
          done           = cnt_q == deg_i;
        end
      end
      default: begin
        res  = '0;
        done = 1'b1;
      end
    endcase
  end

  assign load    = !q_empty_i && (!out_valid_q || pop_i);
  assign q_pop_o = load && done;

  always_comb begin
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    if (load) begin
      cnt_d       = done ? '0 : cnt_q + DEG_W'(1);
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      result_q <= res;
    end
  end

  assign empty_o  = !out_valid_q;
  assign result_o = result_q;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the serial CRC generate/check block.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned MAX_DEG    = 16;
  localparam int unsigned QUIET_LIMIT = 3000;
  localparam int unsigned DIRECTED_N  = 42;
  localparam int unsigned RANDOM_N    = 278;

  // Bit-level model of the divider plus the results it still owes.
  class crc_tracker;
    logic [4:0]          degree;
    logic [15:0]         taps;
    logic                check;
    logic [MAX_DEG-1:0]  rem;
    scgc_pkg::out_item_t expected_results[$];
    int                  mismatches;

    function new();
      degree     = scgc_pkg::DEGREE_RST;
      taps       = scgc_pkg::TAPS_RST;
      check      = 1'b0;
      rem        = '0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        scgc_pkg::REG_DEGREE: degree = value[4:0];
        scgc_pkg::REG_TAPS:   taps   = value[15:0];
        scgc_pkg::REG_MODE:   check  = value[0];
        default: ;
      endcase
    endfunction

    function void predict_bit(scgc_pkg::in_item_t it);
      int unsigned        d;
      logic [MAX_DEG-1:0] mask;
      logic [MAX_DEG-1:0] tp;
      logic [MAX_DEG-1:0] r;
      logic               top;
      d = degree;
      if (d < 1) d = 1;
      if (d > MAX_DEG) d = MAX_DEG;
      mask = MAX_DEG'((17'd1 << d) - 17'd1);
      tp   = taps & mask;
      r    = rem & mask;
      top  = r[d-1];
      if (check) begin
        r = ((r << 1) | MAX_DEG'(it.data_bit)) & mask;
        if (top) r ^= tp;
        if (it.last_bit) begin
          expected_results.push_back('{1'b0, 1'b0, 1'b1, r != '0});
          r = '0;
        end
      end else begin
        // augmented division: top bit and data bit together decide the subtract
        r = (r << 1) & mask;
        if (top ^ it.data_bit) r ^= tp;
        expected_results.push_back('{it.data_bit, 1'b0, 1'b0, 1'b0});
        if (it.last_bit) begin
          for (int i = 0; i < d; i++)
            expected_results.push_back('{r[d-1-i], 1'b1, i == d - 1, 1'b0});
          r = '0;
        end
      end
      rem = r;
    endfunction

    function void compare_result(scgc_pkg::out_item_t got);
      scgc_pkg::out_item_t exp_item;
      string               names [4];
      names = '{"error_flag", "frame_end", "is_crc_bit", "code_bit"};
      if (expected_results.size() == 0) begin
        $error("unexpected result item %b", got);
        mismatches++;
        return;
      end
      exp_item = expected_results.pop_front();
      for (int i = 0; i < 4; i++)
        if (got[i] !== exp_item[i]) begin
          $error("%s: expected %b, got %b", names[i], exp_item[i], got[i]);
          mismatches++;
        end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic                        clk_i   = 1'b0;
  logic                        rst_ni  = 1'b0;
  logic                        push    = 1'b0;
  logic                        full;
  scgc_pkg::in_item_t          data_i  = '0;
  logic                        empty;
  logic                        pop     = 1'b0;
  scgc_pkg::out_item_t         result_o;
  logic                        psel    = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite  = 1'b0;
  logic [scgc_pkg::APB_AW-1:0] paddr   = '0;
  logic [scgc_pkg::APB_DW-1:0] pwdata  = '0;
  logic [scgc_pkg::APB_DW-1:0] prdata;
  logic                        pready;

  crc_tracker tracker = new();

  int burst_left = 0;
  int items_sent = 0;
  int hold_left = 0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int seg_left = 0;
  int pop_pct = 100;
  int quiet = 0;

  serial_crc_generate_check #(.MAX_DEGREE(MAX_DEG)) dut (
    .clk_i, .rst_ni, .push, .full, .data_i, .empty, .pop, .result_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && push && !full) tracker.predict_bit(data_i);
  end

  // Result side: check accepted items, then pick the next pop.
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      tracker.compare_result(result_o);
    end
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      pop <= 1'b0;
      hold_left--;
    end else if (!hold_done && hold_req) begin
      // long hold-off so the queue fills and full asserts
      hold_left = 300;
      hold_done = 1'b1;
      pop <= 1'b0;
    end else begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(1, 40);
        case ($urandom_range(0, 2))
          0:       pop_pct = 100;
          1:       pop_pct = 70;
          default: pop_pct = 25;
        endcase
      end
      seg_left--;
      pop <= ($urandom_range(1, 100) <= pop_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  task automatic send_item(scgc_pkg::in_item_t it);
    if (burst_left == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 120)
                                               : $urandom_range(1, 15);
    end
    push   <= 1'b1;
    data_i <= it;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_bits(logic [63:0] bits, int n, bit with_last);
    for (int i = n - 1; i >= 0; i--)
      send_item('{bits[i], with_last && (i == 0)});
  endtask

  // Stop sending and wait for every owed result, plus slack for silent check steps.
  task automatic drain();
    push <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.set_reg(idx, value);
  endtask

  // Message followed by its CRC under the current settings, from a scratch generator.
  task automatic make_codeword(input logic [63:0] msg, input int n,
                               output logic [63:0] cw, output int cw_n);
    crc_tracker gen;
    gen = new();
    gen.degree = tracker.degree;
    gen.taps   = tracker.taps;
    cw   = msg;
    cw_n = n;
    for (int i = n - 1; i >= 0; i--) gen.predict_bit('{msg[i], i == 0});
    foreach (gen.expected_results[k])
      if (gen.expected_results[k].is_crc_bit) begin
        cw = {cw[62:0], gen.expected_results[k].code_bit};
        cw_n++;
      end
  endtask

  initial begin
    logic [63:0] msg;
    logic [63:0] cw;
    int          cw_n;
    int          len;
    int          kind;
    logic [4:0]  deg;
    logic [15:0] tp;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // receiver holds off while a long frame is offered, so the queue fills
    hold_req = 1'b1;
    send_bits(64'hB5A3, 16, 1'b1);
    drain();

    // reset settings: degree 16, CCITT taps, generate
    send_bits(64'b101, 3, 1'b1);
    drain();
    write_reg(scgc_pkg::REG_DEGREE, 32'd1);
    write_reg(scgc_pkg::REG_TAPS, 32'd1);
    send_bits(64'b1101, 4, 1'b1);
    drain();
    // degree zero acts as one; taps above the degree are dropped
    write_reg(scgc_pkg::REG_DEGREE, 32'd0);
    write_reg(scgc_pkg::REG_TAPS, 32'hFFFF);
    send_bits(64'b10, 2, 1'b1);
    drain();
    // degree above the maximum saturates
    write_reg(scgc_pkg::REG_DEGREE, 32'd31);
    send_bits(64'b11, 2, 1'b1);
    drain();
    write_reg(scgc_pkg::REG_TAPS, 32'd0);
    send_bits(64'b1, 1, 1'b1);
    drain();
    // settings change in the middle of a frame
    write_reg(scgc_pkg::REG_DEGREE, 32'd8);
    write_reg(scgc_pkg::REG_TAPS, 32'h07);
    send_bits(64'b101, 3, 1'b0);
    drain();
    write_reg(scgc_pkg::REG_DEGREE, 32'd5);
    write_reg(scgc_pkg::REG_TAPS, 32'h05);
    send_bits(64'b11, 2, 1'b1);
    drain();
    write_reg(scgc_pkg::REG_MODE, 32'd1);
    write_reg(scgc_pkg::REG_DEGREE, 32'd4);
    write_reg(scgc_pkg::REG_TAPS, 32'h3);
    make_codeword(64'b10, 2, cw, cw_n);
    send_bits(cw, cw_n, 1'b1);
    send_bits(64'b11, 2, 1'b0);
    drain();
    write_reg(scgc_pkg::REG_DEGREE, 32'd3);
    send_bits(64'b0, 1, 1'b1);

    while (items_sent < DIRECTED_N + RANDOM_N) begin
      drain();
      case ($urandom_range(0, 5))
        0:       deg = 5'd0;
        1:       deg = 5'd1;
        2:       deg = 5'd16;
        3:       deg = 5'($urandom_range(17, 31));
        default: deg = 5'($urandom_range(2, 15));
      endcase
      case ($urandom_range(0, 4))
        0:       tp = 16'h0000;
        1:       tp = 16'hFFFF;
        default: tp = 16'($urandom);
      endcase
      write_reg(scgc_pkg::REG_DEGREE, 32'(deg));
      write_reg(scgc_pkg::REG_TAPS, 32'(tp));
      write_reg(scgc_pkg::REG_MODE, 32'($urandom_range(0, 1)));
      repeat ($urandom_range(2, 5)) begin
        len  = $urandom_range(1, 20);
        msg  = {$urandom, $urandom};
        kind = $urandom_range(0, 9);
        if (tracker.check && kind < 8) begin
          make_codeword(msg, len, cw, cw_n);
          if (kind >= 6) cw[$urandom_range(0, cw_n - 1)] ^= 1'b1;
          send_bits(cw, cw_n, 1'b1);
        end else begin
          send_bits(msg, len, 1'b1);
        end
      end
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (tracker.mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// ===== serial_crc_generate_check.f =====
rtl/scgc_pkg.sv
rtl/scgc_front.sv
rtl/scgc_queue.sv
rtl/scgc_back.sv
rtl/serial_crc_generate_check.sv
tb/tb.sv
